### rtl/core/smet_pkg.sv
// Shared types and constants for the sparse matrix entry table.
package smet_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W     = 64;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_DUMP  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_LOADED    = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] value;
  } cmd_t;

endpackage

### rtl/core/smet_front.sv
// Request intake: drops unused codes and queues requests for the back end.
module smet_front import smet_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         kind,
  input  logic [15:0]        row_index,
  input  logic [15:0]        col_index,
  input  logic signed [31:0] entry_value,
  output logic               busy,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       take;

  assign busy      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign push      = start && !busy && (kind != KIND_NONE);
  assign take      = pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: kind, row: row_index, col: col_index, value: entry_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      case ({push, take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/core/smet_back.sv
// Execution: entry memory, load append, and the query/dump walk.
module smet_back import smet_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               pop,
  output logic               done,
  output logic [2:0]         status,
  output logic [15:0]        out_row,
  output logic [15:0]        out_col,
  output logic signed [31:0] out_value,
  output logic               last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] pend;
  logic               pend_vld;
  logic [1:0]         state;
  logic [COUNT_W-1:0] count;
  logic [ADDR_W-1:0]  ptr;
  logic [ADDR_W-1:0]  last_addr;
  logic               issue_done;
  logic               d_vld;
  logic               d_end;
  cmd_t               cur;
  logic               has_room;
  logic               wr_en;
  logic               match;

  assign pop       = (state == S_IDLE) && cmd_valid;
  assign has_room  = count < COUNT_W'(MAX_ENTRIES);
  assign wr_en     = pop && (cmd.kind == KIND_LOAD) && has_room;
  assign last_addr = ADDR_W'(count - COUNT_W'(1));
  assign match     = (rd_data[63:48] == cur.row) && (rd_data[47:32] == cur.col);

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[ADDR_W-1:0]] <= {cmd.row, cmd.col, cmd.value};
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      done       <= 1'b0;
      d_vld      <= 1'b0;
      pend_vld   <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      done  <= 1'b0;
      d_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur        <= cmd;
            ptr        <= '0;
            issue_done <= 1'b0;
            pend_vld   <= 1'b0;
            case (cmd.kind)
              KIND_LOAD: begin
                done      <= 1'b1;
                status    <= has_room ? ST_LOADED : ST_FULL;
                out_row   <= cmd.row;
                out_col   <= cmd.col;
                out_value <= cmd.value;
                last      <= 1'b1;
                if (has_room) count <= count + COUNT_W'(1);
              end
              default: begin
                if (count == '0) begin
                  done      <= 1'b1;
                  last      <= 1'b1;
                  out_value <= '0;
                  if (cmd.kind == KIND_QUERY) begin
                    status  <= ST_NOT_FOUND;
                    out_row <= cmd.row;
                    out_col <= cmd.col;
                  end else begin
                    status  <= ST_EMPTY;
                    out_row <= '0;
                    out_col <= '0;
                  end
                end else begin
                  state <= S_WALK;
                end
              end
            endcase
          end
        end
        S_WALK: begin
          if (!issue_done) begin
            ptr <= ptr + ADDR_W'(1);
            if (ptr == last_addr) issue_done <= 1'b1;
          end
          d_vld <= !issue_done;
          d_end <= (ptr == last_addr);
          if (d_vld) begin
            if (cur.kind == KIND_DUMP) begin
              done      <= 1'b1;
              status    <= ST_FOUND;
              out_row   <= rd_data[63:48];
              out_col   <= rd_data[47:32];
              out_value <= $signed(rd_data[31:0]);
              last      <= d_end;
              if (d_end) state <= S_IDLE;
            end else begin
              if (match) begin
                if (pend_vld) begin
                  done      <= 1'b1;
                  status    <= ST_FOUND;
                  out_row   <= pend[63:48];
                  out_col   <= pend[47:32];
                  out_value <= $signed(pend[31:0]);
                  last      <= 1'b0;
                end
                pend     <= rd_data;
                pend_vld <= 1'b1;
              end
              if (d_end) state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          done     <= 1'b1;
          last     <= 1'b1;
          pend_vld <= 1'b0;
          state    <= S_IDLE;
          if (pend_vld) begin
            status    <= ST_FOUND;
            out_row   <= pend[63:48];
            out_col   <= pend[47:32];
            out_value <= $signed(pend[31:0]);
          end else begin
            status    <= ST_NOT_FOUND;
            out_row   <= cur.row;
            out_col   <= cur.col;
            out_value <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/sparse_matrix_entry_table_unit.sv
// Top level of the sparse matrix entry table.
// A request is taken when start is high and busy is low; up to two requests
// wait in the intake queue and busy rises only when both slots are taken.
// Results come out one per cycle with done high and must be captured then.
// A load result appears in the cycle after its pop. A query or dump walks
// all stored entries, reading one entry per cycle through the single read
// port of the entry memory into a registered read; a query then adds a
// final result state. Kind code 3 is taken and dropped.
module sparse_matrix_entry_table_unit import smet_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [15:0]        row_index,
  input  logic [15:0]        col_index,
  input  logic signed [31:0] entry_value,
  output logic               done,
  output logic [2:0]         status,
  output logic [15:0]        out_row,
  output logic [15:0]        out_col,
  output logic signed [31:0] out_value,
  output logic               last
);

  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  smet_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .kind        (kind),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .busy        (busy),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .pop         (pop)
  );

  smet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .done      (done),
    .status    (status),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .last      (last)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> cmd_valid)
    else $error("pop from empty queue");
  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst) busy |-> cmd_valid)
    else $error("busy with no queued request");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NOT_FOUND || status == ST_EMPTY || status == ST_LOADED ||
              status == ST_FULL)) |-> last)
    else $error("single result without last");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (out_row == '0 && out_col == '0 && out_value == '0))
    else $error("empty dump result not zero");
`endif

endmodule

### dv/tb_sparse_matrix_entry_table_unit.sv
`timescale 1ns / 100ps
// Testbench for the sparse matrix entry table: directed and random requests against a predictor.
module tb_sparse_matrix_entry_table_unit;
  import smet_pkg::*;

  typedef struct {
    logic [2:0]         status;
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] value;
    logic               last;
  } table_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         kind;
  logic [15:0]        row_index;
  logic [15:0]        col_index;
  logic signed [31:0] entry_value;
  logic               done;
  logic [2:0]         status;
  logic [15:0]        out_row;
  logic [15:0]        out_col;
  logic signed [31:0] out_value;
  logic               last;

  logic [15:0]        table_row [MAX_ENTRIES];
  logic [15:0]        table_col [MAX_ENTRIES];
  logic signed [31:0] table_val [MAX_ENTRIES];
  int                 table_count = 0;
  table_result_t      pending_results [$];
  int                 mismatch_count = 0;

  sparse_matrix_entry_table_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .row_index(row_index), .col_index(col_index), .entry_value(entry_value),
    .done(done), .status(status), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void push_result(input logic [2:0] st, input logic [15:0] r,
                                      input logic [15:0] c, input logic signed [31:0] v,
                                      input logic l);
    table_result_t res;
    res.status = st;
    res.row    = r;
    res.col    = c;
    res.value  = v;
    res.last   = l;
    pending_results.push_back(res);
  endfunction

  // Expected results of one accepted request; updates the shadow table.
  function automatic void predict_table(input cmd_t req);
    int last_hit;
    last_hit = -1;
    case (req.kind)
      KIND_LOAD: begin
        if (table_count < MAX_ENTRIES) begin
          table_row[table_count] = req.row;
          table_col[table_count] = req.col;
          table_val[table_count] = req.value;
          table_count++;
          push_result(ST_LOADED, req.row, req.col, req.value, 1'b1);
        end else begin
          push_result(ST_FULL, req.row, req.col, req.value, 1'b1);
        end
      end
      KIND_QUERY: begin
        for (int i = 0; i < table_count; i++)
          if (table_row[i] == req.row && table_col[i] == req.col) last_hit = i;
        if (last_hit < 0) begin
          push_result(ST_NOT_FOUND, req.row, req.col, 32'sd0, 1'b1);
        end else begin
          for (int i = 0; i <= last_hit; i++)
            if (table_row[i] == req.row && table_col[i] == req.col)
              push_result(ST_FOUND, table_row[i], table_col[i], table_val[i], i == last_hit);
        end
      end
      KIND_DUMP: begin
        if (table_count == 0) begin
          push_result(ST_EMPTY, 16'd0, 16'd0, 32'sd0, 1'b1);
        end else begin
          for (int i = 0; i < table_count; i++)
            push_result(ST_FOUND, table_row[i], table_col[i], table_val[i],
                        i == table_count - 1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Drives one request, waits for it to be taken, then optionally idles.
  task automatic send_request(input logic [1:0] k, input logic [15:0] r,
                              input logic [15:0] c, input logic [31:0] v,
                              input bit gaps);
    cmd_t req;
    int   gap_len;
    req.kind  = k;
    req.row   = r;
    req.col   = c;
    req.value = v;
    start       <= 1'b1;
    kind        <= k;
    row_index   <= r;
    col_index   <= c;
    entry_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table(req);
    if (gaps && $urandom_range(0, 2) == 0) begin
      gap_len = $urandom_range(1, 16);
      start       <= 1'b0;
      kind        <= 2'($urandom);
      row_index   <= 16'($urandom);
      col_index   <= 16'($urandom);
      entry_value <= $urandom;
      repeat (gap_len) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($urandom_range(0, 3));
    if (sel < 6) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_random(input int load_pct, input bit gaps);
    int          pick;
    int          idx;
    logic [1:0]  k;
    logic [15:0] r;
    logic [15:0] c;
    pick = $urandom_range(0, 99);
    r = pick_coord();
    c = pick_coord();
    if (pick < load_pct) begin
      k = KIND_LOAD;
    end else if (pick < 95) begin
      k = KIND_QUERY;
      if (table_count > 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, table_count - 1);
        r = table_row[idx];
        c = table_col[idx];
      end
    end else if (pick < 98) begin
      k = KIND_DUMP;
    end else begin
      k = KIND_NONE;
    end
    send_request(k, r, c, $urandom, gaps);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d row %0h col %0h",
                 $time, status, out_row, out_col);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("out_row", 32'(want.row), 32'(out_row));
        check_field("out_col", 32'(want.col), 32'(out_col));
        check_field("out_value", want.value, out_value);
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  task automatic test_empty_and_extremes();
    send_request(KIND_DUMP, 16'h0000, 16'h0000, 32'h0, 1'b1);
    send_request(KIND_QUERY, 16'h0000, 16'h0000, 32'h0, 1'b1);
    send_request(KIND_NONE, 16'h1234, 16'h5678, 32'h9ABCDEF0, 1'b1);
    send_request(KIND_LOAD, 16'h0000, 16'h0000, 32'h7FFFFFFF, 1'b1);
    send_request(KIND_LOAD, 16'hFFFF, 16'hFFFF, 32'h80000000, 1'b1);
    send_request(KIND_LOAD, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b0);
    send_request(KIND_LOAD, 16'hFFFF, 16'h0000, 32'h00000000, 1'b0);
    send_request(KIND_LOAD, 16'h0000, 16'h0000, 32'h00000001, 1'b1);
    send_request(KIND_QUERY, 16'h0000, 16'h0000, 32'hFFFFFFFF, 1'b1);
    send_request(KIND_QUERY, 16'hFFFF, 16'hFFFF, 32'h0, 1'b0);
    send_request(KIND_QUERY, 16'h0000, 16'h0001, 32'h0, 1'b1);
    send_request(KIND_QUERY, 16'hFFFF, 16'h0000, 32'h0, 1'b1);
    send_request(KIND_DUMP, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1);
    send_request(KIND_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b0);
    send_request(KIND_QUERY, 16'h0000, 16'hFFFF, 32'h12345678, 1'b1);
  endtask

  task automatic test_random_fill();
    while (table_count < MAX_ENTRIES) send_random(55, 1'b1);
  endtask

  task automatic test_table_full();
    send_request(KIND_LOAD, 16'hFFFF, 16'hFFFF, 32'h80000000, 1'b1);
    send_request(KIND_LOAD, 16'h0000, 16'h0000, 32'h7FFFFFFF, 1'b0);
    send_request(KIND_DUMP, 16'h0000, 16'h0000, 32'h0, 1'b1);
    send_request(KIND_QUERY, table_row[MAX_ENTRIES-1], table_col[MAX_ENTRIES-1],
                 32'h0, 1'b1);
  endtask

  task automatic test_random_full();
    repeat (190) send_random(20, 1'b1);
  endtask

  task automatic test_back_to_back();
    repeat (50) send_random(30, 1'b0);
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    kind        <= KIND_LOAD;
    row_index   <= 16'd0;
    col_index   <= 16'd0;
    entry_value <= 32'sd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_extremes();
    test_random_fill();
    test_table_full();
    test_random_full();
    test_back_to_back();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
